// ===== sv/qte_pkg.sv =====
// Package for the quaternion to Euler angles unit: payload types, CORDIC
// angle table and fixed constants. No dependencies.
`default_nettype none
package qte_pkg;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic               quat_present;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] roll_deg;
      logic signed [15:0] pitch_deg;
      logic signed [15:0] yaw_deg;
      logic               status;
   } rsp_item_type;

   // Q.30 working words; products of Q2.30 need up to about 36 bits after
   // doubling and summing, CORDIC gain pushes that further.
   localparam int unsigned WORD_W = 40;
   localparam int unsigned ANG_W  = 34;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [WORD_W-1:0] ONE_Q30 = 40'sd1073741824;

   // one root bit per square-root stage; the root of 2^60 needs 31 bits
   localparam int unsigned SQRT_STAGES = 31;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/quaternion_to_euler_angles_unit.sv =====
// Quaternion to ZYX Euler angles unit, top level.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
//
// Usage: the req_ channel carries one quaternion item (four signed Q2.30
// words and a present flag); the rsp_ channel returns roll, pitch and yaw
// in degrees with ANGLE_FRAC_BITS fractional bits plus a status bit (1 when
// the item held no quaternion, angles then zero).
// Throughput: one item per cycle. The whole datapath is one pipeline that
// moves only when its output register is free or being taken.
// Pipeline: a product stage, a sum stage, 31 square-root stages, a
// pre-rotation stage, CORDIC_STAGES rotation stages and 2 scaling stages,
// i.e. CORDIC_STAGES + 36 register stages. The square root of the roll
// path sets that length; pitch and yaw are delayed to match.
// Reset: clears all valid bits; no item is in flight afterwards.
// Stall: when rsp_stall is high with a result waiting, the pipeline holds
// and req_stall rises in the same cycle, so nothing is lost or repeated.
`default_nettype none
module quaternion_to_euler_angles_unit
   import qte_pkg::*;
#(
   parameter int unsigned ANGLE_FRAC_BITS = 7,
   parameter int unsigned CORDIC_STAGES   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);
   localparam int unsigned SQ_LAT = SQRT_STAGES;
   localparam int unsigned DEPTH  = 2 + SQ_LAT + 1 + CORDIC_STAGES + 2;

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] pres_ff;

   // hold everything while the last result waits on a stall
   assign advance   = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end
   always_ff @(posedge clock) begin
      if (advance) pres_ff <= {pres_ff[DEPTH-2:0], req_item.quat_present};
   end

   // stage 1: ten products, floor shifted to Q.30
   logic signed [WORD_W-1:0] p02_ff, p13_ff, p23_ff, p01_ff, p11_ff, p22_ff;
   logic signed [WORD_W-1:0] p12_ff, p03_ff, p00_ff, p33_ff;
   function automatic logic signed [WORD_W-1:0] mq(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return WORD_W'(p >>> 30);
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         p02_ff <= mq(req_item.quat_w, req_item.quat_y);
         p13_ff <= mq(req_item.quat_x, req_item.quat_z);
         p23_ff <= mq(req_item.quat_y, req_item.quat_z);
         p01_ff <= mq(req_item.quat_w, req_item.quat_x);
         p11_ff <= mq(req_item.quat_x, req_item.quat_x);
         p22_ff <= mq(req_item.quat_y, req_item.quat_y);
         p12_ff <= mq(req_item.quat_x, req_item.quat_y);
         p03_ff <= mq(req_item.quat_w, req_item.quat_z);
         p00_ff <= mq(req_item.quat_w, req_item.quat_w);
         p33_ff <= mq(req_item.quat_z, req_item.quat_z);
      end
   end

   // stage 2: sums, clamp of the sine
   logic signed [WORD_W-1:0] s_in, s_ff, py_ff, px_ff, yy_ff, yx_ff;
   always_comb begin
      s_in = (p02_ff - p13_ff) <<< 1;
      if (s_in > ONE_Q30)  s_in = ONE_Q30;
      if (s_in < -ONE_Q30) s_in = -ONE_Q30;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff  <= s_in;
         py_ff <= (p23_ff + p01_ff) <<< 1;
         px_ff <= ONE_Q30 - (p11_ff <<< 1) - (p22_ff <<< 1);
         yy_ff <= (p12_ff + p03_ff) <<< 1;
         yx_ff <= p00_ff + p11_ff - p22_ff - p33_ff;
      end
   end

   // s^2 is at most 2^60; 31-bit magnitude squared
   logic [30:0] s_mag;
   logic [61:0] s_sq;
   logic [60:0] rad;
   logic [30:0] c_root;
   assign s_mag = s_ff[WORD_W-1] ? 31'(-s_ff) : 31'(s_ff);
   assign s_sq  = 62'(s_mag) * 62'(s_mag);
   assign rad   = 61'((62'd1 << 60) - s_sq);

   qte_isqrt u_isqrt (
      .clock(clock), .advance(advance), .rad_in(rad), .root_out(c_root)
   );

   // delay the sine and the pitch/yaw operands to line up with the root
   logic signed [WORD_W-1:0] sd_ff [SQ_LAT];
   logic signed [WORD_W-1:0] pyd_ff [SQ_LAT];
   logic signed [WORD_W-1:0] pxd_ff [SQ_LAT];
   logic signed [WORD_W-1:0] yyd_ff [SQ_LAT];
   logic signed [WORD_W-1:0] yxd_ff [SQ_LAT];
   always_ff @(posedge clock) begin
      if (advance) begin
         sd_ff[0]  <= s_ff;
         pyd_ff[0] <= py_ff;
         pxd_ff[0] <= px_ff;
         yyd_ff[0] <= yy_ff;
         yxd_ff[0] <= yx_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            sd_ff[k]  <= sd_ff[k-1];
            pyd_ff[k] <= pyd_ff[k-1];
            pxd_ff[k] <= pxd_ff[k-1];
            yyd_ff[k] <= yyd_ff[k-1];
            yxd_ff[k] <= yxd_ff[k-1];
         end
      end
   end

   logic signed [15:0] roll_d, pitch_d, yaw_d;
   qte_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock(clock), .advance(advance), .y_in(sd_ff[SQ_LAT-1]),
      .x_in($signed(WORD_W'(c_root))), .deg_out(roll_d)
   );
   qte_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .advance(advance), .y_in(pyd_ff[SQ_LAT-1]),
      .x_in(pxd_ff[SQ_LAT-1]), .deg_out(pitch_d)
   );
   qte_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
      .clock(clock), .advance(advance), .y_in(yyd_ff[SQ_LAT-1]),
      .x_in(yxd_ff[SQ_LAT-1]), .deg_out(yaw_d)
   );

   // drop angles for items without a quaternion
   logic absent;
   assign absent = !pres_ff[DEPTH-1];
   assign rsp_valid          = vld_ff[DEPTH-1];
   assign rsp_item.roll_deg  = absent ? '0 : roll_d;
   assign rsp_item.pitch_deg = absent ? '0 : pitch_d;
   assign rsp_item.yaw_deg   = absent ? '0 : yaw_d;
   assign rsp_item.status    = absent;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status |-> rsp_item.roll_deg == 16'sd0)
      else $error("angles not cleared for missing quaternion");
endmodule
`default_nettype wire

// ===== sv/qte_isqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
// Depends on qte_pkg. c = floor(sqrt(2^60 - s^2)), 31 result bits.
`default_nettype none
module qte_isqrt
   import qte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [60:0]       rad_in,
   output logic      [30:0]       root_out
);
   // rem, partial root and radicand per stage; the radicand is widened to
   // an even bit count so that every stage takes one aligned bit pair
   logic [61:0] rem_ff  [1:SQRT_STAGES-1];
   logic [30:0] root_ff [1:SQRT_STAGES];
   logic [61:0] rad_ff  [1:SQRT_STAGES-1];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      logic [61:0] rem_prev;
      logic [61:0] rad_prev;
      logic [30:0] root_prev;
      logic [61:0] rem_in;
      logic [61:0] trial;
      logic [30:0] root_in;
      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = {1'b0, rad_in};
      end else begin : g_next
         assign rem_prev  = rem_ff[g];
         assign root_prev = root_ff[g];
         assign rad_prev  = rad_ff[g];
      end
      always_comb begin
         rem_in = {rem_prev[59:0], rad_prev[61-2*g -: 2]};
         trial  = {29'd0, root_prev, 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_prev[29:0], 1'b1};
         end else begin
            root_in = {root_prev[29:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) root_ff[g+1] <= root_in;
      end
      if (g < SQRT_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[g+1] <= rem_in;
               rad_ff[g+1] <= rad_prev;
            end
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES];
endmodule
`default_nettype wire

// ===== sv/qte_cordic.sv =====
// Pipelined vectoring CORDIC for atan2 in Q.30, followed by degree scaling.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic
   import qte_pkg::*;
#(
   parameter int unsigned STAGES    = 16,
   parameter int unsigned FRAC_BITS = 7
) (
   input  wire logic                     clock,
   input  wire logic                     advance,
   input  wire logic signed [WORD_W-1:0] y_in,
   input  wire logic signed [WORD_W-1:0] x_in,
   output logic signed [15:0]            deg_out
);
   localparam int unsigned XW = WORD_W + 2;
   logic signed [XW-1:0]    x_ff [STAGES];
   logic signed [XW-1:0]    y_ff [STAGES];
   logic signed [ANG_W-1:0] z_ff [STAGES+1];

   // pre-rotation stage
   always_ff @(posedge clock) begin
      if (advance) begin
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_ff[0] <= XW'(y_in);
               y_ff[0] <= -XW'(x_in);
               z_ff[0] <= HALF_PI_Q30;
            end else begin
               x_ff[0] <= -XW'(y_in);
               y_ff[0] <= XW'(x_in);
               z_ff[0] <= -HALF_PI_Q30;
            end
         end else begin
            x_ff[0] <= XW'(x_in);
            y_ff[0] <= XW'(y_in);
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_rot
      always_ff @(posedge clock) begin
         if (advance) begin
            if (y_ff[g] > 0)      z_ff[g+1] <= z_ff[g] + atan_entry(5'(g));
            else if (y_ff[g] < 0) z_ff[g+1] <= z_ff[g] - atan_entry(5'(g));
            else                  z_ff[g+1] <= z_ff[g];
         end
      end
      // the last stage only needs the angle
      if (g < STAGES - 1) begin : g_xy
         logic signed [XW-1:0] dx, dy;
         assign dx = y_ff[g] >>> g;
         assign dy = x_ff[g] >>> g;
         always_ff @(posedge clock) begin
            if (advance) begin
               if (y_ff[g] > 0) begin
                  x_ff[g+1] <= x_ff[g] + dx;
                  y_ff[g+1] <= y_ff[g] - dy;
               end else if (y_ff[g] < 0) begin
                  x_ff[g+1] <= x_ff[g] - dx;
                  y_ff[g+1] <= y_ff[g] + dy;
               end else begin
                  x_ff[g+1] <= x_ff[g];
                  y_ff[g+1] <= y_ff[g];
               end
            end
         end
      end
   end

   // Scale: q = (|z|*573*2^F + 5*2^30) / (10*2^30). Multiply by 573 and
   // register, then divide by 5 via reciprocal and shift out 2^31.
   localparam int unsigned PW = ANG_W + 10 + FRAC_BITS;
   logic              neg_ff;
   logic [PW-1:0]     prod_ff;
   logic [ANG_W-1:0]  mag;
   assign mag = z_ff[STAGES] < 0 ? ANG_W'(-z_ff[STAGES]) : ANG_W'(z_ff[STAGES]);

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff  <= z_ff[STAGES] < 0;
         prod_ff <= (PW'(mag) * PW'(573)) << FRAC_BITS;
      end
   end

   // q = floor((p + 5*2^30) / (10*2^30)) = floor(floor((p+5*2^30)/2^31) / 5)
   localparam int unsigned HW = PW - 30;
   logic [HW-1:0] hi;
   logic [HW+3:0] qd;
   logic [HW+3:0] rem;
   logic [HW-1:0] q;
   logic [PW:0]   sum;
   assign sum = {1'b0, prod_ff} + (PW+1)'(64'd5 << 30);
   assign hi  = HW'(sum >> 31);
   // small divide-by-5: value fits 24 bits; reciprocal with one correction
   logic [HW+24:0] mulr;
   assign mulr = (HW+25)'(hi) * (HW+25)'(25'd13421773);
   assign qd   = (HW+4)'(mulr >> 26);
   assign rem  = (HW+4)'(hi) - qd * (HW+4)'(5);
   assign q    = (rem >= (HW+4)'(5)) ? HW'(qd + 1'b1) : HW'(qd);

   logic signed [15:0] deg_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (neg_ff) deg_ff <= (q > HW'(32768)) ? -16'sd32768 : -$signed(16'(q));
         else        deg_ff <= (q > HW'(32767)) ? 16'sd32767 : $signed(16'(q));
      end
   end
   assign deg_out = deg_ff;
endmodule
`default_nettype wire

// ===== bench/tb_quaternion_to_euler_angles_unit.sv =====
// Testbench for quaternion_to_euler_angles_unit: directed and random quaternion
// items, checked against an in-bench fixed-point CORDIC predictor.
// Depends on qte_pkg and the unit's RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_quaternion_to_euler_angles_unit
   import qte_pkg::*;
();

   localparam int FRAC_BITS = 7;
   localparam int STAGES    = 16;
   localparam int NUM_RANDOM = 1250;
   // Pipeline depth from the top-level header.
   localparam int PIPE_DEPTH = STAGES + 36;

   // Scoreboard: predicts the Euler angles of each accepted quaternion and
   // matches them in order against the angles that come out.
   class angle_scoreboard;
      rsp_item_type pending[$];
      int           fail_count;

      function new();
         fail_count = 0;
      endfunction

      static function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function longint mul_q30(longint a, longint b);
         return (a * b) >>> 30;
      endfunction

      static function longint root64(longint unsigned v);
         longint unsigned acc, bit_pos;
         acc = 0;
         bit_pos = 64'd1 << 62;
         while (bit_pos > v) bit_pos >>= 2;
         while (bit_pos != 0) begin
            if (v >= acc + bit_pos) begin
               v -= acc + bit_pos;
               acc = (acc >> 1) + bit_pos;
            end else begin
               acc >>= 1;
            end
            bit_pos >>= 2;
         end
         return longint'(acc);
      endfunction

      static function longint atan_table(int i);
         longint tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 7, 3, 1};
         return tab[i];
      endfunction

      static function longint vector_angle(longint y, longint x);
         longint z, t, dx, dy;
         z = 0;
         // Pre-rotate into the right half plane by a quarter turn.
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = HALF_PI_Q30;
            end else begin
               x = -y; y = t; z = -HALF_PI_Q30;
            end
         end
         for (int i = 0; i < STAGES && i < 30; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
               x += dx; y -= dy; z += atan_table(i);
            end else if (y < 0) begin
               x -= dx; y += dy; z -= atan_table(i);
            end
         end
         return z;
      endfunction

      static function logic signed [15:0] radians_to_degrees(longint z);
         longint unsigned mag, num, quo;
         bit neg;
         neg = z < 0;
         mag = neg ? -z : z;
         num = ((mag * 573) << FRAC_BITS) + (64'd5 << 30);
         quo = num / (64'd10 << 30);
         if (neg) return (quo > 32768) ? -16'sd32768 : 16'(-longint'(quo));
         return (quo > 32767) ? 16'sd32767 : 16'(quo);
      endfunction

      function void note_quaternion(req_item_type q);
         rsp_item_type r;
         longint q0, q1, q2, q3, s, py, px, yy, yx, c;
         r = '0;
         if (!q.quat_present) begin
            r.status = 1'b1;
         end else begin
            q0 = q.quat_w; q1 = q.quat_x; q2 = q.quat_y; q3 = q.quat_z;
            s = 2 * (mul_q30(q0, q2) - mul_q30(q1, q3));
            // Clamp the sine to one where asin would be undefined.
            if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
            if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
            c = root64((64'd1 << 60) - longint'(s * s));
            py = 2 * (mul_q30(q2, q3) + mul_q30(q0, q1));
            px = (64'sd1 << 30) - 2 * mul_q30(q1, q1) - 2 * mul_q30(q2, q2);
            yy = 2 * (mul_q30(q1, q2) + mul_q30(q0, q3));
            yx = mul_q30(q0, q0) + mul_q30(q1, q1) - mul_q30(q2, q2)
               - mul_q30(q3, q3);
            r.roll_deg  = radians_to_degrees(vector_angle(s, c));
            r.pitch_deg = radians_to_degrees(vector_angle(py, px));
            r.yaw_deg   = radians_to_degrees(vector_angle(yy, yx));
         end
         pending.push_back(r);
      endfunction

      function void check_angles(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", got);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         if (got.roll_deg !== want.roll_deg) begin
            $error("roll_deg: expected %0d, got %0d", want.roll_deg, got.roll_deg);
            fail_count++;
         end
         if (got.pitch_deg !== want.pitch_deg) begin
            $error("pitch_deg: expected %0d, got %0d", want.pitch_deg, got.pitch_deg);
            fail_count++;
         end
         if (got.yaw_deg !== want.yaw_deg) begin
            $error("yaw_deg: expected %0d, got %0d", want.yaw_deg, got.yaw_deg);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   int           rsp_wait = 0;

   angle_scoreboard angles = new();
   bit              driving_done = 1'b0;

   always #6 clock = ~clock;

   quaternion_to_euler_angles_unit #(
      .ANGLE_FRAC_BITS(FRAC_BITS),
      .CORDIC_STAGES(STAGES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   // Sample both channels at the rising edge; note inputs before checking
   // so an item that could pass straight through still finds its prediction.
   // Draw the receiver's wait for the next result on each taken result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) angles.note_quaternion(req_item);
         if (rsp_valid && !rsp_stall) begin
            angles.check_angles(rsp_item);
            rsp_wait <= $urandom_range(0, 3);
         end
      end
   end

   // Receiver: stall each waiting result until its drawn wait has counted down.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= $urandom_range(0, 3);
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one item after a drawn gap and hold it until accepted.
   task automatic send_quaternion(req_item_type q);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic req_item_type make_quat(int w, int x, int y, int z, bit p);
      req_item_type q;
      q.quat_w = w; q.quat_x = x; q.quat_y = y; q.quat_z = z;
      q.quat_present = p;
      return q;
   endfunction

   function automatic int unit_component();
      // Mostly values within [-1, 1], sometimes any 32-bit word.
      case ($urandom_range(0, 9))
         0:       return int'($urandom());
         1:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         2:       return 0;
         default: return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      endcase
   endfunction

   initial begin
      req_item_type q;
      int one, h;
      one = 32'sh4000_0000;
      h   = 32'sh2d41_3ccd;   // about 1/sqrt(2)
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity, axis turns, gimbal lock, clamp, zeros, extremes, absent items.
      send_quaternion(make_quat(one, 0, 0, 0, 1));
      send_quaternion(make_quat(0, one, 0, 0, 1));
      send_quaternion(make_quat(0, 0, one, 0, 1));
      send_quaternion(make_quat(0, 0, 0, one, 1));
      send_quaternion(make_quat(-one, 0, 0, 0, 1));
      send_quaternion(make_quat(h, 0, h, 0, 1));
      send_quaternion(make_quat(h, 0, -h, 0, 1));
      send_quaternion(make_quat(h, h, 0, 0, 1));
      send_quaternion(make_quat(h, 0, 0, -h, 1));
      send_quaternion(make_quat(one, 0, one, 0, 1));
      send_quaternion(make_quat(one, one, -one, one, 1));
      send_quaternion(make_quat(0, 0, 0, 0, 1));
      send_quaternion(make_quat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh7fff_ffff, 1));
      send_quaternion(make_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh8000_0000, 1));
      send_quaternion(make_quat(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                                32'sh8000_0000, 1));
      send_quaternion(make_quat(-1, -1, -1, -1, 1));
      send_quaternion(make_quat(one, 0, 0, 0, 0));
      send_quaternion(make_quat(-1, -1, -1, -1, 0));

      // Random: mostly present quaternions, some absent.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         q = make_quat(unit_component(), unit_component(), unit_component(),
                       unit_component(), $urandom_range(0, 9) != 0);
         send_quaternion(q);
      end
      req_valid <= 1'b0;
      driving_done = 1'b1;
   end

   // Finish once every prediction is matched and the pipe has drained.
   initial begin
      wait (driving_done);
      while (angles.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (angles.fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
